// ----- hw/rtl/fsa_pkg.sv -----
// Shared types and codes for the frequency state auction block.
// Used by the sequencer (top level) and the shared arithmetic unit.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package fsa_pkg;

  // Operation codes carried by an input word.
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_RUN  = 1'b1;

  // Functions of the shared arithmetic unit.
  typedef enum logic [1:0] {
    AR_MUL,
    AR_SQDIST,
    AR_DIST
  } arith_op_t;

  // Sequencer states.
  typedef enum logic [4:0] {
    ST_IDLE,
    ST_BLD_RD,
    ST_BLD_CAP,
    ST_BLD_SQ,
    ST_BLD_WR,
    ST_ROUND,
    ST_SC_RD,
    ST_SC_ACC,
    ST_SC_MUL,
    ST_SC_CMP,
    ST_DECIDE,
    ST_PK_RD,
    ST_PK_CMP,
    ST_CH_RD,
    ST_CH_DIST,
    ST_CH_SUB,
    ST_OUT_RD,
    ST_OUT_EMIT
  } state_t;

endpackage

`default_nettype wire

// ----- hw/rtl/fsa_ram.sv -----
// Generic single-port RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module fsa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    addr,
  input  wire logic [WIDTH-1:0] wdata,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Registered read; a read at the address being written returns the old contents.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

// ----- hw/rtl/fsa_arith.sv -----
// Shared arithmetic unit: one multiplier with a registered result.
// It forms products, squared score values and state distances.
// Depends on fsa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fsa_arith #(
  parameter int NUM_STATES = 8,
  parameter int A_W        = 10
) (
  input  wire logic                clk,
  input  wire fsa_pkg::arith_op_t  op,
  input  wire logic [A_W-1:0]      a,
  input  wire logic [7:0]          b,
  output logic      [A_W+7:0]      y
);

  import fsa_pkg::*;

  localparam int SIW = $clog2(NUM_STATES);

  logic [SIW-1:0] a_s;
  logic [SIW-1:0] b_s;
  logic [SIW-1:0] sdist;
  logic [SIW:0]   closeness;
  logic [A_W-1:0] mul_a;
  logic [7:0]     mul_b;

  // Distance between two states and the closeness value derived from it.
  always_comb begin
    a_s       = a[SIW-1:0];
    b_s       = b[SIW-1:0];
    sdist     = (a_s > b_s) ? (a_s - b_s) : (b_s - a_s);
    closeness = (SIW+1)'(NUM_STATES) - {1'b0, sdist};
  end

  // Operand selection for the single multiplier.
  always_comb begin
    unique case (op)
      AR_MUL: begin
        mul_a = a;
        mul_b = b;
      end
      AR_SQDIST: begin
        mul_a = A_W'(closeness);
        mul_b = 8'(closeness);
      end
      AR_DIST: begin
        mul_a = A_W'(sdist);
        mul_b = 8'd1;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Registered product.
  always_ff @(posedge clk) begin
    y <= mul_a * mul_b;
  end

endmodule

`default_nettype wire

// ----- hw/rtl/frequency_state_auction_top.sv -----
// Frequency state auction: sequencer, demand registers and storage.
// Depends on fsa_pkg, fsa_ram and fsa_arith.
//
// Channel  | Direction | Handshake              | Word
// ---------+-----------+------------------------+-------------------------------------------
// command  | in        | start && !busy         | operation, state_index, demand_value, budget
// result   | out       | valid (one-cycle pulse) | cpu_index, new_state, changed, last
//
// A load word completes in the cycle it is accepted; busy stays low.
// A run, paced by the one score memory port, builds scores, runs R auction
// rounds, makes a closing check (budget spent or no demand left) and emits
// C result words (C = NUM_CPUS, S = NUM_STATES); the receiver cannot stall.
// Synchronous reset clears demand, current states and the sequencer.
`timescale 1ns / 1ps
`default_nettype none

module frequency_state_auction_top #(
  parameter int NUM_CPUS   = 8,
  parameter int NUM_STATES = 8
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       start,
  output logic            busy,
  input  wire logic       operation,
  input  wire logic [2:0] state_index,
  input  wire logic [7:0] demand_value,
  input  wire logic [7:0] budget,
  output logic            valid,
  output logic      [2:0] cpu_index,
  output logic      [2:0] new_state,
  output logic            changed,
  output logic            last
);

  import fsa_pkg::*;

  localparam int SIW    = $clog2(NUM_STATES);
  localparam int CW     = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
  localparam int SCW    = $clog2(NUM_STATES * NUM_STATES + 1);
  localparam int CSW    = $clog2(NUM_CPUS * NUM_STATES * NUM_STATES + 1);
  localparam int PW     = CSW + 8;
  localparam int SDEPTH = NUM_CPUS << SIW;
  localparam int SAW    = $clog2(SDEPTH);

  state_t state;
  state_t state_next;

  logic [CW-1:0]     c_cnt;
  logic [SIW-1:0]    s_cnt;
  logic [CSW-1:0]    colsum;
  logic [SIW-1:0]    win;
  logic [PW-1:0]     win_val;
  logic [7:0]        win_dem;
  logic [CW-1:0]     best;
  logic [SCW-1:0]    best_val;
  logic signed [8:0] remaining;
  logic [SIW-1:0]    cur_q;
  logic [7:0]        demand [NUM_STATES];
  logic [NUM_CPUS-1:0] cur_vld;
  logic              cur_rd_vld;

  logic [SAW-1:0]    score_addr;
  logic              score_we;
  logic [SCW-1:0]    score_wdata;
  logic [SCW-1:0]    score_rdata;
  logic [CW-1:0]     cur_addr;
  logic              cur_we;
  logic [SIW-1:0]    cur_rdata;
  logic [CW-1:0]     pend_addr;
  logic              pend_we;
  logic [SIW:0]      pend_wdata;
  logic [SIW:0]      pend_rdata;

  arith_op_t         ar_op;
  logic [CSW-1:0]    ar_a;
  logic [7:0]        ar_b;
  logic [PW-1:0]     ar_y;

  logic              c_last;
  logic              s_last;
  logic [SIW-1:0]    cur_val;
  logic [SIW-1:0]    ns_val;

  assign busy    = (state != ST_IDLE);
  assign c_last  = (c_cnt == CW'(NUM_CPUS - 1));
  assign s_last  = (s_cnt == SIW'(NUM_STATES - 1));
  // A cpu never written since reset reads as state 0.
  assign cur_val = cur_rd_vld ? cur_rdata : '0;
  // An unassigned cpu falls back to state 0.
  assign ns_val  = pend_rdata[SIW] ? pend_rdata[SIW-1:0] : '0;

  // Score table, one entry per cpu/state pair.
  fsa_ram #(.WIDTH(SCW), .DEPTH(SDEPTH)) u_score (
    .clk   (clk),
    .we    (score_we),
    .addr  (score_addr),
    .wdata (score_wdata),
    .rdata (score_rdata)
  );

  // Current state of each cpu.
  fsa_ram #(.WIDTH(SIW), .DEPTH(NUM_CPUS)) u_cur (
    .clk   (clk),
    .we    (cur_we),
    .addr  (cur_addr),
    .wdata (ns_val),
    .rdata (cur_rdata)
  );

  // Pending assignment of each cpu; the top bit marks it assigned.
  fsa_ram #(.WIDTH(SIW + 1), .DEPTH(NUM_CPUS)) u_pend (
    .clk   (clk),
    .we    (pend_we),
    .addr  (pend_addr),
    .wdata (pend_wdata),
    .rdata (pend_rdata)
  );

  fsa_arith #(.NUM_STATES(NUM_STATES), .A_W(CSW)) u_arith (
    .clk (clk),
    .op  (ar_op),
    .a   (ar_a),
    .b   (ar_b),
    .y   (ar_y)
  );

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state, memory controls and arithmetic operand selection.
  always_comb begin
    state_next  = state;
    score_addr  = SAW'({c_cnt, s_cnt});
    score_we    = 1'b0;
    score_wdata = SCW'(ar_y);
    cur_addr    = c_cnt;
    cur_we      = 1'b0;
    pend_addr   = c_cnt;
    pend_we     = 1'b0;
    pend_wdata  = '0;
    ar_op       = AR_MUL;
    ar_a        = colsum;
    ar_b        = demand[s_cnt];
    unique case (state)
      ST_IDLE: begin
        if (start && operation == OP_RUN) begin
          state_next = ST_BLD_RD;
        end
      end
      ST_BLD_RD: begin
        state_next = ST_BLD_CAP;
      end
      ST_BLD_CAP: begin
        pend_we    = 1'b1;
        state_next = ST_BLD_SQ;
      end
      ST_BLD_SQ: begin
        ar_op      = AR_SQDIST;
        ar_a       = CSW'(s_cnt);
        ar_b       = 8'(cur_q);
        state_next = ST_BLD_WR;
      end
      ST_BLD_WR: begin
        score_we = 1'b1;
        if (!s_last) begin
          state_next = ST_BLD_SQ;
        end else if (c_last) begin
          state_next = ST_ROUND;
        end else begin
          state_next = ST_BLD_RD;
        end
      end
      ST_ROUND: begin
        state_next = (remaining > 9'sd0) ? ST_SC_RD : ST_OUT_RD;
      end
      ST_SC_RD: begin
        state_next = ST_SC_ACC;
      end
      ST_SC_ACC: begin
        state_next = c_last ? ST_SC_MUL : ST_SC_RD;
      end
      ST_SC_MUL: begin
        state_next = ST_SC_CMP;
      end
      ST_SC_CMP: begin
        state_next = s_last ? ST_DECIDE : ST_SC_RD;
      end
      ST_DECIDE: begin
        state_next = (win_val == '0) ? ST_OUT_RD : ST_PK_RD;
      end
      ST_PK_RD: begin
        score_addr = SAW'({c_cnt, win});
        state_next = ST_PK_CMP;
      end
      ST_PK_CMP: begin
        state_next = c_last ? ST_CH_RD : ST_PK_RD;
      end
      ST_CH_RD: begin
        cur_addr   = best;
        state_next = ST_CH_DIST;
      end
      ST_CH_DIST: begin
        ar_op       = AR_DIST;
        ar_a        = CSW'(win);
        ar_b        = 8'(cur_val);
        pend_addr   = best;
        pend_we     = 1'b1;
        pend_wdata  = {1'b1, win};
        score_addr  = SAW'({best, win});
        score_we    = 1'b1;
        score_wdata = '0;
        state_next  = ST_CH_SUB;
      end
      ST_CH_SUB: begin
        state_next = ST_ROUND;
      end
      ST_OUT_RD: begin
        state_next = ST_OUT_EMIT;
      end
      ST_OUT_EMIT: begin
        cur_we     = 1'b1;
        state_next = c_last ? ST_IDLE : ST_OUT_RD;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Valid flag of the current state entry that is being read.
  always_ff @(posedge clk) begin
    cur_rd_vld <= cur_vld[cur_addr];
  end

  // Demand registers, written-cpu flags, round bookkeeping and result word.
  always_ff @(posedge clk) begin
    if (rst) begin
      demand  <= '{default: '0};
      cur_vld <= '0;
      valid   <= 1'b0;
    end else begin
      valid <= 1'b0;
      if (cur_we) begin
        cur_vld[cur_addr] <= 1'b1;
      end
      unique case (state)
        ST_IDLE: begin
          if (start && operation == OP_LOAD && 32'(state_index) < NUM_STATES) begin
            demand[SIW'(state_index)] <= demand_value;
          end
          c_cnt     <= '0;
          s_cnt     <= '0;
          remaining <= $signed({1'b0, budget});
        end
        ST_BLD_CAP: begin
          cur_q <= cur_val;
          s_cnt <= '0;
        end
        ST_BLD_WR: begin
          if (s_last) begin
            s_cnt <= '0;
            c_cnt <= c_cnt + 1'b1;
          end else begin
            s_cnt <= s_cnt + 1'b1;
          end
        end
        ST_ROUND: begin
          c_cnt   <= '0;
          s_cnt   <= '0;
          colsum  <= '0;
          win     <= '0;
          win_val <= '0;
          win_dem <= '0;
        end
        ST_SC_ACC: begin
          colsum <= colsum + CSW'(score_rdata);
          c_cnt  <= c_last ? '0 : c_cnt + 1'b1;
        end
        ST_SC_CMP: begin
          // First state with the strictly largest product wins.
          if (ar_y > win_val) begin
            win     <= s_cnt;
            win_val <= ar_y;
            win_dem <= demand[s_cnt];
          end
          colsum <= '0;
          s_cnt  <= s_cnt + 1'b1;
        end
        ST_DECIDE: begin
          if (win_val != '0) begin
            demand[win] <= win_dem - 8'd1;
          end
          c_cnt    <= '0;
          best     <= '0;
          best_val <= '0;
        end
        ST_PK_CMP: begin
          // First cpu with the strictly highest score; cpu 0 if none.
          if (score_rdata > best_val) begin
            best     <= c_cnt;
            best_val <= score_rdata;
          end
          c_cnt <= c_cnt + 1'b1;
        end
        ST_CH_SUB: begin
          remaining <= remaining - $signed(9'(ar_y));
        end
        ST_OUT_EMIT: begin
          valid     <= 1'b1;
          cpu_index <= 3'(c_cnt);
          new_state <= 3'(ns_val);
          changed   <= (ns_val != cur_val);
          last      <= c_last;
          c_cnt     <= c_cnt + 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // Result words never come on consecutive cycles.
  assert property (@(posedge clk) disable iff (rst) valid |=> !valid)
    else $error("result strobe on consecutive cycles");

  // Every result word comes from the emit step.
  assert property (@(posedge clk) disable iff (rst) valid |-> $past(state) == ST_OUT_EMIT)
    else $error("result strobe outside the emit step");

  // A round only scans while budget remains.
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_SC_RD) |-> (remaining > 9'sd0))
    else $error("scan started with no budget left");

  // A nonzero winning product implies the winner still has demand.
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_DECIDE && win_val != '0) |-> (win_dem != 8'd0))
    else $error("winner has zero demand");

  // The cpu search only runs for a real winner.
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_PK_RD) |-> (win_val != '0))
    else $error("cpu search without a winning state");

endmodule

`default_nettype wire

// ----- tb/frequency_state_auction_top_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for frequency_state_auction_top: directed and random
// demand loads and auction runs, checked word by word by a predicting scoreboard.
// Depends on fsa_pkg and the frequency_state_auction_top RTL.

module frequency_state_auction_top_tb;
  import fsa_pkg::*;

  localparam int NCPU = 8;
  localparam int NSTATE = 8;
  localparam int TARGET_WORDS = 370;
  localparam int DRAIN_CYCLES = 400;
  localparam longint CYCLE_LIMIT = 20_000_000;
  localparam int PRINT_CAP = 50;

  // One result word: the state given to one cpu by a run.
  typedef struct packed {
    logic [2:0] cpu;
    logic [2:0] pstate;
    logic       changed;
    logic       last;
  } cpu_word_t;

  // Keeps its own copy of cpu states and demand, predicts the words of each run
  // and compares every emitted word with the oldest prediction.
  class auction_scoreboard;
    logic [2:0] cpu_state [NCPU];
    logic [7:0] demand [NSTATE];
    cpu_word_t expected_q [$];
    int mismatches;
    int words_checked;
    int loads;
    int runs;
    int rounds;
    int free_rounds;
    int overdrawn_runs;
    int state_changes;

    function new();
      foreach (cpu_state[c]) cpu_state[c] = '0;
      foreach (demand[s]) demand[s] = '0;
    endfunction

    function int distance(int a, int b);
      return (a > b) ? a - b : b - a;
    endfunction

    // Applies one accepted command word; a run queues one word per cpu.
    function void note_command(logic op, logic [2:0] idx, logic [7:0] dv, logic [7:0] bud);
      int score [NCPU][NSTATE];
      int target [NCPU];
      int left;
      int col;
      int top_val;
      int top_state;
      int pick_val;
      int pick_cpu;
      int gap;
      int ns;
      cpu_word_t w;
      if (op == OP_LOAD) begin
        demand[idx] = dv;
        loads++;
        return;
      end
      runs++;
      left = bud;
      // Score every cpu/state pair by closeness to the cpu's present state.
      for (int c = 0; c < NCPU; c++) begin
        for (int s = 0; s < NSTATE; s++) begin
          gap = distance(s, int'(cpu_state[c]));
          score[c][s] = (NSTATE - gap) * (NSTATE - gap);
        end
        target[c] = -1;
      end
      // Auction rounds: the state with the largest demand-weighted column wins.
      while (left > 0) begin
        top_val = 0;
        top_state = 0;
        for (int s = 0; s < NSTATE; s++) begin
          col = 0;
          for (int c = 0; c < NCPU; c++) col += score[c][s];
          col *= int'(demand[s]);
          if (col > top_val) begin
            top_val = col;
            top_state = s;
          end
        end
        if (top_val == 0) break;
        demand[top_state] = demand[top_state] - 8'd1;
        pick_val = 0;
        pick_cpu = 0;
        for (int c = 0; c < NCPU; c++) begin
          if (score[c][top_state] > pick_val) begin
            pick_val = score[c][top_state];
            pick_cpu = c;
          end
        end
        gap = distance(int'(cpu_state[pick_cpu]), top_state);
        if (gap == 0) free_rounds++;
        left -= gap;
        if (left < 0) overdrawn_runs++;
        target[pick_cpu] = top_state;
        score[pick_cpu][top_state] = 0;
        rounds++;
      end
      // Cpus that won nothing fall back to state 0.
      for (int c = 0; c < NCPU; c++) begin
        ns = (target[c] < 0) ? 0 : target[c];
        w.cpu = 3'(c);
        w.pstate = 3'(ns);
        w.changed = (3'(ns) != cpu_state[c]);
        w.last = (c == NCPU - 1);
        if (w.changed) state_changes++;
        cpu_state[c] = 3'(ns);
        expected_q.push_back(w);
      end
    endfunction

    task report_mismatch(string msg);
      mismatches++;
      // Further mismatches are only counted.
      if (mismatches <= PRINT_CAP) $display("%0t ns: mismatch: %s", $time, msg);
    endtask

    task check_result(logic [2:0] ci, logic [2:0] ns, logic ch, logic lst);
      cpu_word_t w;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("word for cpu %0d (state %0d) with no run pending", ci, ns));
        return;
      end
      w = expected_q.pop_front();
      words_checked++;
      if (ci !== w.cpu)
        report_mismatch($sformatf("cpu_index %0d, expected %0d", ci, w.cpu));
      if (ns !== w.pstate)
        report_mismatch($sformatf("cpu %0d new_state %0d, expected %0d", w.cpu, ns, w.pstate));
      if (ch !== w.changed)
        report_mismatch($sformatf("cpu %0d changed %0b, expected %0b", w.cpu, ch, w.changed));
      if (lst !== w.last)
        report_mismatch($sformatf("cpu %0d last %0b, expected %0b", w.cpu, lst, w.last));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic operation = 1'b0;
  logic [2:0] state_index = '0;
  logic [7:0] demand_value = '0;
  logic [7:0] budget = '0;
  logic busy;
  logic valid;
  logic [2:0] cpu_index;
  logic [2:0] new_state;
  logic changed;
  logic last;

  auction_scoreboard board = new();
  int idle_pct = 0;
  int words_sent = 0;
  longint cycle_count = 0;

  frequency_state_auction_top #(
    .NUM_CPUS(NCPU),
    .NUM_STATES(NSTATE)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .operation(operation),
    .state_index(state_index),
    .demand_value(demand_value),
    .budget(budget),
    .valid(valid),
    .cpu_index(cpu_index),
    .new_state(new_state),
    .changed(changed),
    .last(last)
  );

  // Free-running clock, 20 ns period.
  initial begin
    forever #10 clk = ~clk;
  end

  // Every strobed result word goes to the scoreboard.
  always @(posedge clk) begin
    if (!rst && valid === 1'b1) board.check_result(cpu_index, new_state, changed, last);
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d words outstanding.", cycle_count,
               board.expected_q.size());
      $display("frequency_state_auction_top_tb: FAIL");
      $finish;
    end
  end

  // Offers one command word, with random idle cycles first, and waits for it to be taken.
  task automatic send_word(logic op, logic [2:0] idx, logic [7:0] dv, logic [7:0] bud);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    start <= 1'b1;
    operation <= op;
    state_index <= idx;
    demand_value <= dv;
    budget <= bud;
    do @(posedge clk); while (busy);
    board.note_command(op, idx, dv, bud);
    words_sent++;
  endtask

  // Holds off new commands until every predicted word has come out.
  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk);
    while (board.expected_q.size() != 0) @(posedge clk);
  endtask

  // Mostly a few loads followed by a run; some loads alone and some bare runs as noise.
  task automatic random_phase(int pct, int upto);
    int kind;
    int n_loads;
    int r;
    logic [7:0] dv;
    logic [7:0] bud;
    idle_pct = pct;
    while (words_sent < upto) begin
      kind = $urandom_range(99);
      n_loads = (kind >= 8 && kind < 16) ? 0 : $urandom_range(1, 4);
      repeat (n_loads) begin
        r = $urandom_range(99);
        // Small demands keep runs short; a few large ones stress long auctions.
        if (r < 84) dv = 8'($urandom_range(0, 3));
        else if (r < 92) dv = 8'($urandom);
        else if (r < 96) dv = 8'hFF;
        else dv = 8'h00;
        send_word(OP_LOAD, 3'($urandom_range(7)), dv, 8'($urandom));
      end
      if (kind >= 8) begin
        r = $urandom_range(99);
        if (r < 10) bud = 8'h00;
        else if (r < 20) bud = 8'hFF;
        else bud = 8'($urandom_range(1, 254));
        if ($urandom_range(99) < 5) wait_drained();
        send_word(OP_RUN, 3'($urandom_range(7)), 8'($urandom), bud);
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: zero budget, empty demand, extreme fields, free rounds and overdraw.
    send_word(OP_RUN, 3'd5, 8'hAA, 8'h00);
    send_word(OP_RUN, 3'd0, 8'h00, 8'hFF);
    send_word(OP_LOAD, 3'd7, 8'hFF, 8'hFF);
    send_word(OP_LOAD, 3'd0, 8'h00, 8'h00);
    send_word(OP_LOAD, 3'd3, 8'h02, 8'h5A);
    send_word(OP_RUN, 3'd7, 8'hFF, 8'hFF);
    send_word(OP_RUN, 3'd2, 8'h11, 8'h00);
    send_word(OP_LOAD, 3'd7, 8'h00, 8'h00);
    send_word(OP_LOAD, 3'd3, 8'h00, 8'h00);
    send_word(OP_LOAD, 3'd0, 8'h03, 8'h00);
    send_word(OP_LOAD, 3'd4, 8'h01, 8'h00);
    // All cpus sit in state 0: three free rounds, then a charge past the budget.
    send_word(OP_RUN, 3'd0, 8'h00, 8'h01);
    send_word(OP_LOAD, 3'd2, 8'h55, 8'h00);
    send_word(OP_LOAD, 3'd5, 8'hAA, 8'h00);
    send_word(OP_LOAD, 3'd6, 8'h01, 8'h00);
    send_word(OP_LOAD, 3'd1, 8'h01, 8'h00);
    send_word(OP_RUN, 3'd6, 8'h01, 8'h0F);
    send_word(OP_LOAD, 3'd2, 8'h00, 8'h00);
    send_word(OP_LOAD, 3'd5, 8'h00, 8'h00);
    send_word(OP_RUN, 3'd3, 8'h07, 8'h80);
    wait_drained();

    // Random: light sender idling, then heavy, then back to back.
    random_phase(29, words_sent + (TARGET_WORDS - words_sent) / 3);
    wait_drained();
    random_phase(65, words_sent + (TARGET_WORDS - words_sent) / 2);
    wait_drained();
    random_phase(0, TARGET_WORDS);
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d demand loads and %0d auctions: %0d rounds, %0d free, %0d overdrawn.",
             board.loads, board.runs, board.rounds, board.free_rounds, board.overdrawn_runs);
    $display("Checked %0d cpu words (%0d state changes); %0d mismatches.",
             board.words_checked, board.state_changes, board.mismatches);
    if (board.mismatches == 0 && board.expected_q.size() == 0) begin
      $display("frequency_state_auction_top_tb: PASS");
    end else begin
      $display("frequency_state_auction_top_tb: FAIL");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/fsa_pkg.sv
hw/rtl/fsa_ram.sv
hw/rtl/fsa_arith.sv
hw/rtl/frequency_state_auction_top.sv
tb/frequency_state_auction_top_tb.sv
